### sv/crvm_pkg.sv
// Shared types, codes and constants for the clip resampling voice mixer.
// Used by the top level, the port checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package crvm_pkg;

   // default sizing, handed to the top level parameters
   localparam int CLIP_WORDS_DEF   = 65536;
   localparam int MAX_CHANNELS_DEF = 2;

   localparam int SAMPLE_W   = 16;
   localparam int MIX_W      = 24;
   localparam int STEP_W     = 20;
   localparam int VOLUME_W   = 16;
   localparam int FRAMES_W   = 17;
   localparam int CHANCFG_W  = 2;
   localparam int PLAYHEAD_W = 36;
   localparam int FRAC_W     = 16;
   localparam int LOAD_ADDR_W = 16;
   // frame index times channel count plus channel, before wrapping to the RAM
   localparam int ADDR_RAW_W = FRAMES_W + 1;
   localparam int MUL_W      = 18;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam logic [STEP_W-1:0]    STEP_RESET     = 20'd65536;
   localparam logic [VOLUME_W-1:0]  VOLUME_RESET   = 16'd32768;
   localparam logic [FRAMES_W-1:0]  FRAMES_RESET   = 17'd16;
   localparam logic [CHANCFG_W-1:0] CHANCFG_RESET  = 2'd2;

   typedef enum logic [2:0] {
      KIND_LOAD   = 3'd0,
      KIND_RENDER = 3'd1,
      KIND_PLAY   = 3'd2,
      KIND_STOP   = 3'd3,
      KIND_PAUSE  = 3'd4,
      KIND_RESUME = 3'd5
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEP     = 3'd0,
      CSR_VOLUME   = 3'd1,
      CSR_LOOP     = 3'd2,
      CSR_FRAMES   = 3'd3,
      CSR_CHANNELS = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_RD1,
      ST_RD2,
      ST_DIFF,
      ST_MULF,
      ST_INTERP,
      ST_MULV,
      ST_ACC,
      ST_ADV,
      ST_WRAP,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [2:0]                 kind;
      logic [LOAD_ADDR_W-1:0]     load_address;
      logic signed [SAMPLE_W-1:0] load_sample;
      logic signed [MIX_W-1:0]    mix_in_first;
      logic signed [MIX_W-1:0]    mix_in_second;
   } req_type;

   typedef struct packed {
      logic signed [MIX_W-1:0] mix_out_first;
      logic signed [MIX_W-1:0] mix_out_second;
      logic                    is_playing;
      logic                    reached_end;
   } rsp_type;

endpackage

`default_nettype wire

### sv/clip_resampling_voice_mixer.sv
// Render request: accepted in IDLE, then EVAL and FIN when not playing or at a non-looping
// end; otherwise RD1, RD2, DIFF, MULF, INTERP, MULV and ACC per channel, ADV, WRAP passes
// when looping, then FIN. Only one render is in flight at a time.
// One shared 18x18 multiplier and a single clip RAM read port serialise these steps.
// Load and control requests are handled in IDLE. Synchronous active-high reset
// clears playhead, playing flag, registers to their defaults; the clip RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module clip_resampling_voice_mixer #(
   parameter int CLIP_WORDS   = crvm_pkg::CLIP_WORDS_DEF,   // power of two
   parameter int MAX_CHANNELS = crvm_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire crvm_pkg::req_type                   req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output crvm_pkg::rsp_type                        rsp_payload,
   input  wire logic                                csr_we,
   input  wire logic [crvm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [crvm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW       = $clog2(CLIP_WORDS);
   localparam int RD_EXT_W = (AW > crvm_pkg::ADDR_RAW_W) ? AW : crvm_pkg::ADDR_RAW_W;
   localparam int WR_EXT_W = (AW > crvm_pkg::LOAD_ADDR_W) ? AW : crvm_pkg::LOAD_ADDR_W;

   // configuration
   logic [crvm_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [crvm_pkg::VOLUME_W-1:0]  volume_ff, volume_in;
   logic                           loop_ff, loop_in;
   logic [crvm_pkg::FRAMES_W-1:0]  frames_ff, frames_in;
   logic [crvm_pkg::CHANCFG_W-1:0] chancfg_ff, chancfg_in;

   // voice state and datapath
   crvm_pkg::state_type               state_ff, state_in;
   logic [crvm_pkg::PLAYHEAD_W-1:0]   ph_ff, ph_in;
   logic                              playing_ff, playing_in;
   logic                              reached_ff, reached_in;
   logic                              ch_ff, ch_in;
   logic signed [crvm_pkg::SAMPLE_W-1:0] s1_ff, s1_in;
   logic signed [crvm_pkg::SAMPLE_W:0]   diff_ff, diff_in;
   logic signed [2*crvm_pkg::MUL_W-1:0]  prod_ff, prod_in;
   logic signed [crvm_pkg::SAMPLE_W-1:0] interp_ff, interp_in;
   logic signed [crvm_pkg::MIX_W-1:0]    mix0_ff, mix0_in;
   logic signed [crvm_pkg::MIX_W-1:0]    mix1_ff, mix1_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   crvm_pkg::rsp_type                 rsp_ff, rsp_in;

   // combinational helpers
   logic                              req_take;
   logic                              two_ch;
   logic                              last_ch;
   logic                              at_end;
   logic [crvm_pkg::PLAYHEAD_W-1:0]   limit;
   logic                              limit_nz;
   logic                              wrap_more;
   logic                              rsp_busy;
   logic [crvm_pkg::FRAMES_W-1:0]     frame_sel;
   logic [crvm_pkg::ADDR_RAW_W-1:0]   raw_addr;
   logic [RD_EXT_W-1:0]               rd_ext;
   logic [WR_EXT_W-1:0]               wr_ext;
   logic                              ram_we;
   logic [AW-1:0]                     ram_waddr;
   logic [AW-1:0]                     ram_raddr;
   logic [crvm_pkg::SAMPLE_W-1:0]     ram_rdata;
   logic signed [crvm_pkg::MUL_W-1:0] mul_a;
   logic signed [crvm_pkg::MUL_W-1:0] mul_b;
   logic signed [crvm_pkg::SAMPLE_W:0]  interp_sum;
   logic signed [crvm_pkg::SAMPLE_W:0]  scaled;
   logic signed [crvm_pkg::MIX_W:0]     acc_sum;
   logic signed [crvm_pkg::MIX_W-1:0]   acc_sel;
   logic signed [crvm_pkg::MIX_W-1:0]   acc_sat;

   crvm_ram #(
      .WIDTH (crvm_pkg::SAMPLE_W),
      .DEPTH (CLIP_WORDS)
   ) u_clip_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_payload.load_sample),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_take  = req_valid && !req_stall;
   assign two_ch    = (MAX_CHANNELS > 1) && chancfg_ff[1];
   assign last_ch   = !two_ch || ch_ff;
   assign at_end    = ({1'b0, ph_ff[crvm_pkg::PLAYHEAD_W-1:crvm_pkg::FRAC_W]} + 21'd1)
                      >= {4'd0, frames_ff};
   assign limit     = {3'd0, frames_ff, 16'd0};
   assign limit_nz  = (frames_ff != '0);
   assign wrap_more = (ph_ff >= limit);
   assign rsp_busy  = rsp_valid_ff && rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crvm_pkg::ST_IDLE: begin
            if (req_take && req_payload.kind == crvm_pkg::KIND_RENDER) begin
               state_in = crvm_pkg::ST_EVAL;
            end
         end
         crvm_pkg::ST_EVAL: begin
            if (!playing_ff || (at_end && !loop_ff)) begin
               state_in = crvm_pkg::ST_FIN;
            end else begin
               state_in = crvm_pkg::ST_RD1;
            end
         end
         crvm_pkg::ST_RD1:    state_in = crvm_pkg::ST_RD2;
         crvm_pkg::ST_RD2:    state_in = crvm_pkg::ST_DIFF;
         crvm_pkg::ST_DIFF:   state_in = crvm_pkg::ST_MULF;
         crvm_pkg::ST_MULF:   state_in = crvm_pkg::ST_INTERP;
         crvm_pkg::ST_INTERP: state_in = crvm_pkg::ST_MULV;
         crvm_pkg::ST_MULV:   state_in = crvm_pkg::ST_ACC;
         crvm_pkg::ST_ACC:    state_in = last_ch ? crvm_pkg::ST_ADV : crvm_pkg::ST_RD1;
         crvm_pkg::ST_ADV:    state_in = loop_ff ? crvm_pkg::ST_WRAP : crvm_pkg::ST_FIN;
         crvm_pkg::ST_WRAP: begin
            if (!(wrap_more && limit_nz)) begin
               state_in = crvm_pkg::ST_FIN;
            end
         end
         crvm_pkg::ST_FIN: begin
            if (!rsp_busy) begin
               state_in = crvm_pkg::ST_IDLE;
            end
         end
         default: state_in = crvm_pkg::ST_IDLE;
      endcase
   end

   // state machine outputs: handshake, RAM ports, multiplier operands
   always_comb begin
      req_stall = (state_ff != crvm_pkg::ST_IDLE);
      ram_we    = (state_ff == crvm_pkg::ST_IDLE) && req_valid
                  && (req_payload.kind == crvm_pkg::KIND_LOAD);
      wr_ext    = WR_EXT_W'(req_payload.load_address);
      ram_waddr = wr_ext[AW-1:0];

      // second read of a channel fetches the next frame
      if (state_ff == crvm_pkg::ST_RD2) begin
         frame_sel = ph_ff[crvm_pkg::FRAC_W +: crvm_pkg::FRAMES_W] + 17'd1;
      end else begin
         frame_sel = ph_ff[crvm_pkg::FRAC_W +: crvm_pkg::FRAMES_W];
      end
      raw_addr  = two_ch ? {frame_sel, ch_ff} : {1'b0, frame_sel};
      rd_ext    = RD_EXT_W'(raw_addr);
      ram_raddr = rd_ext[AW-1:0];

      if (state_ff == crvm_pkg::ST_MULF) begin
         mul_a = {diff_ff[crvm_pkg::SAMPLE_W], diff_ff};
         mul_b = {2'b00, ph_ff[crvm_pkg::FRAC_W-1:0]};
      end else begin
         mul_a = {{2{interp_ff[crvm_pkg::SAMPLE_W-1]}}, interp_ff};
         mul_b = {2'b00, volume_ff};
      end
   end

   // datapath next values
   always_comb begin
      step_in      = step_ff;
      volume_in    = volume_ff;
      loop_in      = loop_ff;
      frames_in    = frames_ff;
      chancfg_in   = chancfg_ff;
      ph_in        = ph_ff;
      playing_in   = playing_ff;
      reached_in   = reached_ff;
      ch_in        = ch_ff;
      s1_in        = s1_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      interp_in    = interp_ff;
      mix0_in      = mix0_ff;
      mix1_in      = mix1_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // floor of the weighted difference over 2^16, added to the first sample
      interp_sum = {s1_ff[crvm_pkg::SAMPLE_W-1], s1_ff} + prod_ff[32:16];
      // floor of interp times volume over 2^15
      scaled     = prod_ff[31:15];
      acc_sel    = ch_ff ? mix1_ff : mix0_ff;
      acc_sum    = {acc_sel[crvm_pkg::MIX_W-1], acc_sel}
                   + {{8{scaled[crvm_pkg::SAMPLE_W]}}, scaled};
      if (acc_sum[crvm_pkg::MIX_W] != acc_sum[crvm_pkg::MIX_W-1]) begin
         acc_sat = acc_sum[crvm_pkg::MIX_W] ? {1'b1, {(crvm_pkg::MIX_W-1){1'b0}}}
                                            : {1'b0, {(crvm_pkg::MIX_W-1){1'b1}}};
      end else begin
         acc_sat = acc_sum[crvm_pkg::MIX_W-1:0];
      end

      if (csr_we) begin
         case (csr_index)
            crvm_pkg::CSR_STEP:     step_in    = csr_wdata[crvm_pkg::STEP_W-1:0];
            crvm_pkg::CSR_VOLUME:   volume_in  = csr_wdata[crvm_pkg::VOLUME_W-1:0];
            crvm_pkg::CSR_LOOP:     loop_in    = csr_wdata[0];
            crvm_pkg::CSR_FRAMES:   frames_in  = csr_wdata[crvm_pkg::FRAMES_W-1:0];
            crvm_pkg::CSR_CHANNELS: chancfg_in = csr_wdata[crvm_pkg::CHANCFG_W-1:0];
            default: ;
         endcase
      end

      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         crvm_pkg::ST_IDLE: begin
            if (req_take) begin
               case (req_payload.kind)
                  crvm_pkg::KIND_RENDER: begin
                     mix0_in    = req_payload.mix_in_first;
                     mix1_in    = req_payload.mix_in_second;
                     reached_in = 1'b0;
                     ch_in      = 1'b0;
                  end
                  crvm_pkg::KIND_PLAY: begin
                     ph_in      = '0;
                     playing_in = 1'b1;
                  end
                  crvm_pkg::KIND_STOP: begin
                     ph_in      = '0;
                     playing_in = 1'b0;
                  end
                  crvm_pkg::KIND_PAUSE:  playing_in = 1'b0;
                  crvm_pkg::KIND_RESUME: playing_in = 1'b1;
                  default: ;
               endcase
            end
         end
         crvm_pkg::ST_EVAL: begin
            if (playing_ff && at_end) begin
               ph_in = '0;
               if (!loop_ff) begin
                  playing_in = 1'b0;
                  reached_in = 1'b1;
               end
            end
         end
         crvm_pkg::ST_RD2:    s1_in = ram_rdata;
         crvm_pkg::ST_DIFF: begin
            diff_in = {ram_rdata[crvm_pkg::SAMPLE_W-1], ram_rdata}
                      - {s1_ff[crvm_pkg::SAMPLE_W-1], s1_ff};
         end
         crvm_pkg::ST_MULF:   prod_in = mul_a * mul_b;
         crvm_pkg::ST_INTERP: interp_in = interp_sum[crvm_pkg::SAMPLE_W-1:0];
         crvm_pkg::ST_MULV:   prod_in = mul_a * mul_b;
         crvm_pkg::ST_ACC: begin
            if (ch_ff) begin
               mix1_in = acc_sat;
            end else begin
               mix0_in = acc_sat;
            end
            if (!last_ch) begin
               ch_in = 1'b1;
            end
         end
         crvm_pkg::ST_ADV: begin
            ph_in = ph_ff + {16'd0, step_ff};
         end
         crvm_pkg::ST_WRAP: begin
            // subtract one clip length per pass
            if (wrap_more) begin
               ph_in = limit_nz ? (ph_ff - limit) : '0;
            end
         end
         crvm_pkg::ST_FIN: begin
            if (!rsp_busy) begin
               rsp_valid_in          = 1'b1;
               rsp_in.mix_out_first  = mix0_ff;
               rsp_in.mix_out_second = mix1_ff;
               rsp_in.is_playing     = playing_ff;
               rsp_in.reached_end    = reached_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crvm_pkg::ST_IDLE;
         step_ff      <= crvm_pkg::STEP_RESET;
         volume_ff    <= crvm_pkg::VOLUME_RESET;
         loop_ff      <= 1'b0;
         frames_ff    <= crvm_pkg::FRAMES_RESET;
         chancfg_ff   <= crvm_pkg::CHANCFG_RESET;
         ph_ff        <= '0;
         playing_ff   <= 1'b0;
         reached_ff   <= 1'b0;
         ch_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         volume_ff    <= volume_in;
         loop_ff      <= loop_in;
         frames_ff    <= frames_in;
         chancfg_ff   <= chancfg_in;
         ph_ff        <= ph_in;
         playing_ff   <= playing_in;
         reached_ff   <= reached_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff     <= s1_in;
      diff_ff   <= diff_in;
      prod_ff   <= prod_in;
      interp_ff <= interp_in;
      mix0_ff   <= mix0_in;
      mix1_ff   <= mix1_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

### sv/crvm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the interleaved clip samples.
`timescale 1ns / 1ps
`default_nettype none

module crvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

### sv/crvm_checker.sv
// Port-level checks for the clip resampling voice mixer, bound to the top level.
// Depends on crvm_pkg for the request and result types.
`timescale 1ns / 1ps
`default_nettype none

module crvm_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire crvm_pkg::req_type req_payload,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire crvm_pkg::rsp_type rsp_payload
);

   // hold a stalled result
   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result valid dropped while stalled");

   a_rsp_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("result payload changed while stalled");

   // an end flag means playback stopped
   a_end_not_playing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.reached_end |-> !rsp_payload.is_playing)
      else $error("reached_end with playing flag set");

   a_reset_no_result: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a render request keeps the block busy on the next cycle
   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.kind == crvm_pkg::KIND_RENDER)
      |=> req_stall)
      else $error("render request did not occupy the voice");

endmodule

bind clip_resampling_voice_mixer crvm_checker u_crvm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

### dv/testbench.sv
// Self-checking bench for the clip resampling voice mixer: random and directed
// requests against a cycle-free voice predictor. Needs crvm_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
   import crvm_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 8;
   localparam int SETTLE       = 40;    // longest render plus margin
   localparam int LONG_HOLD    = 400;
   localparam int TIMEOUT_NS   = 30_000_000;
   localparam int SIDE_SEND    = 0;
   localparam int SIDE_RECV    = 1;

   localparam logic [2:0] KIND_SPARE_A = 3'd6;
   localparam logic [2:0] KIND_SPARE_B = 3'd7;

   localparam logic [MIX_W-1:0] MIX_HI = 24'h7FFFFF;
   localparam logic [MIX_W-1:0] MIX_LO = 24'h800000;
   localparam longint MIX_HI_VALUE = 8388607;
   localparam longint MIX_LO_VALUE = -8388608;
   localparam logic [STEP_W-1:0] STEP_TOP = 20'hFFFFF;
   localparam logic [STEP_W-1:0] STEP_MAX = 20'd524288;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   always #HALF_PERIOD clock = ~clock;

   clip_resampling_voice_mixer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // voice state as the block should hold it
   logic signed [SAMPLE_W-1:0] clip_model [CLIP_WORDS_DEF];
   bit                         clip_written [CLIP_WORDS_DEF];
   logic [PLAYHEAD_W-1:0]      voice_head = '0;
   bit                         voice_playing = 1'b0;
   logic [STEP_W-1:0]          cfg_step = STEP_RESET;
   logic [VOLUME_W-1:0]        cfg_volume = VOLUME_RESET;
   bit                         cfg_loop = 1'b0;
   logic [FRAMES_W-1:0]        cfg_frames = FRAMES_RESET;
   logic [CHANCFG_W-1:0]       cfg_chans = CHANCFG_RESET;

   req_type request_queue [$];
   rsp_type render_results_due [$];
   rsp_type due_head;

   int     mismatches = 0;
   int     quiet_left [2];
   int     send_gap = 0;
   int     recv_gap = 0;
   int     hold_left = 0;
   bit     long_hold_request = 1'b0;
   longint phase_renders = 0;
   longint frames_covered = 0;

   task automatic report(input string msg);
      $display("[%0t] ERROR %s", $time, msg);
      mismatches++;
   endtask

   function automatic int idle_length(input int side);
      int r;
      if (quiet_left[side] > 0) begin
         quiet_left[side]--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         quiet_left[side] = $urandom_range(30, 100);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   function automatic int eff_channels();
      if (cfg_chans == 0) return 1;
      if (cfg_chans > MAX_CHANNELS_DEF) return MAX_CHANNELS_DEF;
      return cfg_chans;
   endfunction

   // interpolate between two frames, then apply the volume
   function automatic longint interp_scaled(input longint frame, input int frac,
                                            input int nch, input int ch);
      longint s1, s2, w, interp, vol;
      s1 = clip_model[16'(frame * nch + ch)];
      s2 = clip_model[16'((frame + 1) * nch + ch)];
      vol = cfg_volume;
      w = s1 * (65536 - frac) + s2 * frac;
      interp = w >>> 16;
      return (interp * vol) >>> 15;
   endfunction

   function automatic logic signed [MIX_W-1:0] sat_mix(input longint v);
      if (v > MIX_HI_VALUE) return MIX_HI;
      if (v < MIX_LO_VALUE) return MIX_LO;
      return v[MIX_W-1:0];
   endfunction

   task automatic predict_voice(input req_type r);
      longint  mix_acc [2];
      longint  frame, limit;
      int      frac, nch;
      bit      ended;
      rsp_type e;
      case (r.kind)
         KIND_LOAD:   clip_model[r.load_address] = r.load_sample;
         KIND_PLAY:   begin
            voice_head = '0;
            voice_playing = 1'b1;
         end
         KIND_STOP:   begin
            voice_head = '0;
            voice_playing = 1'b0;
         end
         KIND_PAUSE:  voice_playing = 1'b0;
         KIND_RESUME: voice_playing = 1'b1;
         KIND_RENDER: begin
            mix_acc[0] = $signed(r.mix_in_first);
            mix_acc[1] = $signed(r.mix_in_second);
            nch = eff_channels();
            ended = 1'b0;
            if (voice_playing) begin
               frame = voice_head >> FRAC_W;
               frac = int'(voice_head[FRAC_W-1:0]);
               if (frame + 1 >= cfg_frames) begin
                  voice_head = '0;
                  if (cfg_loop) begin
                     frame = 0;
                     frac = 0;
                  end else begin
                     voice_playing = 1'b0;
                     ended = 1'b1;
                  end
               end
               if (voice_playing) begin
                  for (int ch = 0; ch < nch; ch++)
                     mix_acc[ch] += interp_scaled(frame, frac, nch, ch);
                  limit = longint'(cfg_frames) << FRAC_W;
                  voice_head = voice_head + cfg_step;
                  if (cfg_loop && voice_head >= limit)
                     voice_head = (limit == 0) ? '0 : 36'(longint'(voice_head) % limit);
               end
            end
            e.mix_out_first = sat_mix(mix_acc[0]);
            e.mix_out_second = sat_mix(mix_acc[1]);
            e.is_playing = voice_playing;
            e.reached_end = ended;
            render_results_due.push_back(e);
         end
         default: ;
      endcase
   endtask

   // driver: offer pending requests with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_voice(req_payload);
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
               req_payload <= request_queue.pop_front();
               req_valid <= 1'b1;
               send_gap = idle_length(SIDE_SEND);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check accepted results, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (render_results_due.size() == 0) begin
               report("result arrived with no render outstanding");
            end else begin
               due_head = render_results_due.pop_front();
               if (rsp_payload.mix_out_first !== due_head.mix_out_first)
                  report($sformatf("mix_out_first got %0d expected %0d",
                     $signed(rsp_payload.mix_out_first), $signed(due_head.mix_out_first)));
               if (rsp_payload.mix_out_second !== due_head.mix_out_second)
                  report($sformatf("mix_out_second got %0d expected %0d",
                     $signed(rsp_payload.mix_out_second), $signed(due_head.mix_out_second)));
               if (rsp_payload.is_playing !== due_head.is_playing)
                  report($sformatf("is_playing got %b expected %b",
                     rsp_payload.is_playing, due_head.is_playing));
               if (rsp_payload.reached_end !== due_head.reached_end)
                  report($sformatf("reached_end got %b expected %b",
                     rsp_payload.reached_end, due_head.reached_end));
            end
         end
         if (long_hold_request) begin
            hold_left = LONG_HOLD;
            long_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else begin
            recv_gap = idle_length(SIDE_RECV);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [MIX_W-1:0] rand_mix();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return MIX_HI;
      if (r < 20) return MIX_LO;
      if (r < 25) return '0;
      return MIX_W'($urandom);
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'h7FFF;
      if (r < 20) return 16'h8000;
      return SAMPLE_W'($urandom);
   endfunction

   task automatic push_item(input logic [2:0] kind, input logic [LOAD_ADDR_W-1:0] addr,
                            input logic [SAMPLE_W-1:0] sample,
                            input logic [MIX_W-1:0] m1, input logic [MIX_W-1:0] m2);
      req_type r;
      r.kind = kind;
      r.load_address = addr;
      r.load_sample = sample;
      r.mix_in_first = m1;
      r.mix_in_second = m2;
      request_queue.push_back(r);
   endtask

   task automatic push_control(input logic [2:0] kind);
      push_item(kind, 16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
   endtask

   task automatic push_load(input logic [LOAD_ADDR_W-1:0] addr,
                            input logic [SAMPLE_W-1:0] sample);
      clip_written[addr] = 1'b1;
      push_item(KIND_LOAD, addr, sample, 24'($urandom), 24'($urandom));
   endtask

   // load every frame this render could reach before queuing it
   task automatic push_render(input logic [MIX_W-1:0] m1, input logic [MIX_W-1:0] m2);
      longint reach, total;
      int nch;
      logic [LOAD_ADDR_W-1:0] a;
      phase_renders++;
      nch = eff_channels();
      reach = ((phase_renders * longint'(cfg_step)) >>> FRAC_W) + 2;
      total = (cfg_frames < 2) ? 2 : cfg_frames;
      if (reach > total) reach = total;
      while (frames_covered < reach) begin
         for (int ch = 0; ch < nch; ch++) begin
            a = 16'(frames_covered * nch + ch);
            if (!clip_written[a]) push_load(a, rand_sample());
         end
         frames_covered++;
      end
      push_item(KIND_RENDER, 16'($urandom), 16'($urandom), m1, m2);
   endtask

   task automatic push_random(input int count);
      int r;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 45)      push_render(rand_mix(), rand_mix());
         else if (r < 72) push_load(16'($urandom), rand_sample());
         else if (r < 75) push_control(KIND_PLAY);
         else if (r < 77) push_control(KIND_STOP);
         else if (r < 86) push_control(KIND_PAUSE);
         else if (r < 96) push_control(KIND_RESUME);
         else if (r < 98) push_control(KIND_SPARE_A);
         else             push_control(KIND_SPARE_B);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (request_queue.size() != 0 || req_valid || render_results_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_STEP:     cfg_step = value[STEP_W-1:0];
         CSR_VOLUME:   cfg_volume = value[VOLUME_W-1:0];
         CSR_LOOP:     cfg_loop = value[0];
         CSR_FRAMES:   cfg_frames = value[FRAMES_W-1:0];
         CSR_CHANNELS: cfg_chans = value[CHANCFG_W-1:0];
         default: ;
      endcase
   endtask

   // drain, reprogram, and restart the playhead from zero
   task automatic begin_phase(input logic [STEP_W-1:0] step, input logic [VOLUME_W-1:0] vol,
                              input bit loop_on, input logic [FRAMES_W-1:0] frames,
                              input logic [CHANCFG_W-1:0] chans);
      wait_idle();
      write_csr(CSR_STEP, step);
      write_csr(CSR_VOLUME, vol);
      write_csr(CSR_LOOP, loop_on);
      write_csr(CSR_FRAMES, frames);
      write_csr(CSR_CHANNELS, chans);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      phase_renders = 0;
      frames_covered = 0;
      push_control(KIND_PLAY);
   endtask

   initial begin
      int p;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: passthrough, unused kinds, saturation both ways, pause, resume and stop
      push_load(16'd0, 16'h7FFF);
      push_load(16'd1, 16'h8000);
      push_load(16'd2, 16'h7FFF);
      push_load(16'd3, 16'h8000);
      push_load(16'hFFFF, rand_sample());
      push_render(MIX_HI, MIX_LO);
      push_control(KIND_SPARE_A);
      push_control(KIND_SPARE_B);
      push_control(KIND_PLAY);
      push_render(MIX_HI, MIX_LO);
      push_render('0, '0);
      push_control(KIND_PAUSE);
      push_render(rand_mix(), rand_mix());
      push_control(KIND_RESUME);
      push_render(MIX_LO, MIX_HI);
      push_control(KIND_STOP);
      push_render(rand_mix(), rand_mix());

      // an eight-frame step without looping runs into the clip end
      begin_phase(STEP_MAX, 16'hFFFF, 1'b0, 17'd16, 2'd1);
      repeat (4) push_render(rand_mix(), rand_mix());
      push_control(KIND_RESUME);
      push_render(rand_mix(), rand_mix());

      // near-full-clip step with looping wraps after the advance
      begin_phase(STEP_TOP, VOLUME_RESET, 1'b1, 17'd16, 2'd3);
      repeat (3) push_render(rand_mix(), rand_mix());

      begin_phase(20'd65536, VOLUME_RESET, 1'b1, 17'd16, 2'd2);
      push_random(150);
      @(negedge clock);
      long_hold_request = 1'b1;

      begin_phase(20'($urandom_range(65536, 300000)), 16'($urandom), 1'b0,
                  17'($urandom_range(16, 40)), 2'd1);
      push_random(75);
      wait_idle();
      push_random(75);

      begin_phase('0, '0, 1'b0, 17'd16, 2'd0);
      push_random(60);

      begin_phase(STEP_MAX, 16'hFFFF, 1'b1, 17'd65536, 2'd2);
      push_random(60);

      begin_phase(STEP_TOP, VOLUME_RESET, 1'b1, 17'd17, 2'd3);
      push_random(100);

      begin_phase(20'($urandom_range(0, 200000)), 16'($urandom), 1'b0, 17'h1FFFF, 2'd2);
      push_random(60);

      begin_phase(20'd65536, 16'($urandom), 1'b1, '0, 2'd1);
      push_random(40);

      for (p = 0; p < 4; p++) begin
         begin_phase(20'($urandom_range(0, 300000)), 16'($urandom),
                     1'($urandom_range(0, 1)), 17'($urandom_range(16, 64)),
                     2'($urandom_range(0, 3)));
         push_random(150);
      end

      wait_idle();
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule

### clip_resampling_voice_mixer.f
sv/crvm_pkg.sv
sv/crvm_ram.sv
sv/clip_resampling_voice_mixer.sv
sv/crvm_checker.sv
dv/testbench.sv
